### rtl/sha1rc_pkg.sv
// ----------------------------------------------------------------------------
// sha1rc_pkg
// Shared types, constants and helpers for the SHA-1 chain step core.
// ----------------------------------------------------------------------------
package sha1rc_pkg;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned NumDigits = 6;
  localparam int unsigned NumTargets = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned IdxW = 7;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] REDUCE_MOD = 32'd2176782336;  // 36^6
  localparam logic [31:0] DIV9_MAGIC = 32'h38E38E39;    // ceil(2^33 / 9)
  localparam logic [7:0]  CH_A = 8'h61;
  localparam logic [7:0]  CH_0 = 8'h30;

  // register indexes of the target digest words
  typedef enum logic [CfgIdxW-1:0] {
    REG_TGT0 = 3'd0,
    REG_TGT1 = 3'd1,
    REG_TGT2 = 3'd2,
    REG_TGT3 = 3'd3,
    REG_TGT4 = 3'd4
  } cfg_reg_t;

  // working state of one round stage
  typedef struct packed {
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       c;
    logic [31:0]       d;
    logic [31:0]       e;
    logic [15:0][31:0] w;   // w[0] is this round's schedule word
    logic [IdxW-1:0]   idx;
  } round_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned s);
    rotl = (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [7:0] b36_char(input logic [5:0] dig);
    b36_char = (dig < 6'd10) ? CH_0 + {2'b00, dig} : CH_A + {2'b00, dig} - 8'd10;
  endfunction

endpackage

### rtl/sha1_rainbow_chain_step_core.sv
// ----------------------------------------------------------------------------
// sha1_rainbow_chain_step_core
// One rainbow chain link: SHA-1 of an 8-byte candidate, reduction to the
// next "a0" + six base-36 digit candidate, and a match against a target.
// ----------------------------------------------------------------------------
// channel | dir | beat contents
// in_     | in  | tdata: candidate_text[63:0], reduction_index[70:64]
// out_    | out | tdata: digest_h0..h4 (32b each), reduced_text; tuser: hash_match
// cfg_    | in  | cfg_index selects target word 0..4, cfg_data is the word
//
// One beat in and one out per cycle while out_ is not stalled. Stages: input
// register, 80 round stages, digest add, reduce multiply, modulo fold and six
// digit stages (one reciprocal multiply each). A stall on out_ freezes the whole
// pipe; in_tready = !out_tvalid || out_tready. Reset clears valids and targets.
// cfg_ready is always high; write targets only while the pipe is empty.
// ----------------------------------------------------------------------------
module sha1_rainbow_chain_step_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [71:0]                   in_tdata,   // candidate_text, reduction_index
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [223:0]                  out_tdata,  // digest_h0..h4, reduced_text
  output logic [0:0]                    out_tuser,  // hash_match
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sha1rc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import sha1rc_pkg::*;

  localparam int unsigned FinStg = NumRounds + 1;   // digest add
  localparam int unsigned RedStg = NumRounds + 2;   // h0 + h1*idx
  localparam int unsigned ModStg = NumRounds + 3;   // fold into 36^6
  localparam int unsigned LastStg = ModStg + NumDigits;

  logic advance;
  logic [LastStg:0] vld_r;
  logic [31:0] tgt_r [NumTargets];

  round_t st [NumRounds+1];
  round_t st0_r;

  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;
  assign cfg_ready = 1'b1;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[LastStg-1:0], in_tvalid};
    end
  end

  // target registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumTargets; i++) tgt_r[i] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TGT0: tgt_r[0] <= cfg_data;
        REG_TGT1: tgt_r[1] <= cfg_data;
        REG_TGT2: tgt_r[2] <= cfg_data;
        REG_TGT3: tgt_r[3] <= cfg_data;
        REG_TGT4: tgt_r[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage: load IV and the padded single block
  always_ff @(posedge clk) begin
    if (advance) begin
      st0_r.a <= H0_INIT;
      st0_r.b <= H1_INIT;
      st0_r.c <= H2_INIT;
      st0_r.d <= H3_INIT;
      st0_r.e <= H4_INIT;
      st0_r.w <= {32'd64, 384'd0, 32'h80000000, in_tdata[31:0], in_tdata[63:32]};
      st0_r.idx <= in_tdata[70:64];
    end
  end
  assign st[0] = st0_r;

  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    sha1rc_round u_round (
      .clk (clk),
      .en  (advance),
      .rnd (7'(g)),
      .d   (st[g]),
      .q   (st[g+1])
    );
  end

  // digest add
  logic [31:0]     h_r [NumTargets];
  logic [IdxW-1:0] idx_fin_r;
  always_ff @(posedge clk) begin
    if (advance) begin
      h_r[0]    <= H0_INIT + st[NumRounds].a;
      h_r[1]    <= H1_INIT + st[NumRounds].b;
      h_r[2]    <= H2_INIT + st[NumRounds].c;
      h_r[3]    <= H3_INIT + st[NumRounds].d;
      h_r[4]    <= H4_INIT + st[NumRounds].e;
      idx_fin_r <= st[NumRounds].idx;
    end
  end

  // reduce multiply and match compare; digest then rides along to the end
  logic [31:0]  v_red_r;
  logic [31:0]  v_mod_r;
  logic [159:0] dig_red_r, dig_mod_r;
  logic         m_red_r, m_mod_r;
  logic [38:0]  prod_red;
  logic [159:0] h_cat;
  logic [159:0] t_cat;

  assign prod_red = h_r[1] * idx_fin_r;
  assign h_cat = {h_r[4], h_r[3], h_r[2], h_r[1], h_r[0]};
  assign t_cat = {tgt_r[4], tgt_r[3], tgt_r[2], tgt_r[1], tgt_r[0]};

  always_ff @(posedge clk) begin
    if (advance) begin
      v_red_r   <= h_r[0] + prod_red[31:0];
      dig_red_r <= h_cat;
      m_red_r   <= (h_cat == t_cat);
      // value below 2^32 < 2 * 36^6: one subtract suffices
      v_mod_r   <= (v_red_r >= REDUCE_MOD) ? v_red_r - REDUCE_MOD : v_red_r;
      dig_mod_r <= dig_red_r;
      m_mod_r   <= m_red_r;
    end
  end

  // base-36 digit stages, least significant digit first
  logic [31:0]  dv   [NumDigits+1];
  logic [63:0]  txt  [NumDigits+1];
  logic [159:0] dgd  [NumDigits+1];
  logic         dm   [NumDigits+1];

  assign dv[0]  = v_mod_r;
  assign txt[0] = {CH_A, CH_0, 48'd0};
  assign dgd[0] = dig_mod_r;
  assign dm[0]  = m_mod_r;

  for (genvar p = 0; p < NumDigits; p++) begin : g_dig
    logic [61:0] qprod;
    logic [31:0] quo;
    logic [31:0] rem;
    logic [63:0] txt_nxt;
    logic [31:0] dv_r;
    logic [63:0] txt_r;
    logic [159:0] dgd_r;
    logic        dm_r;

    // v / 36 = ((v >> 2) / 9) via reciprocal
    assign qprod = dv[p][31:2] * DIV9_MAGIC;
    assign quo   = {3'd0, qprod[61:33]};
    assign rem   = dv[p] - ((quo << 5) + (quo << 2));
    always_comb begin
      txt_nxt = txt[p];
      txt_nxt[47-8*p -: 8] = b36_char(rem[5:0]);
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv_r  <= quo;
        txt_r <= txt_nxt;
        dgd_r <= dgd[p];
        dm_r  <= dm[p];
      end
    end
    assign dv[p+1]  = dv_r;
    assign txt[p+1] = txt_r;
    assign dgd[p+1] = dgd_r;
    assign dm[p+1]  = dm_r;
  end

  assign out_tvalid = vld_r[LastStg];
  assign out_tdata  = {txt[NumDigits], dgd[NumDigits]};
  assign out_tuser  = dm[NumDigits];

  // checks
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready path broken");
  a_pref: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[223:208] == {CH_A, CH_0}) else $error("bad prefix");
  a_mod: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ModStg] |-> v_mod_r < REDUCE_MOD) else $error("fold out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(vld_r)) else $error("pipe moved on stall");

endmodule

### rtl/sha1rc_round.sv
// ----------------------------------------------------------------------------
// sha1rc_round
// One registered SHA-1 round with its rolling message schedule window.
// ----------------------------------------------------------------------------
module sha1rc_round (
  input  logic                    clk,
  input  logic                    en,
  input  logic [6:0]              rnd,
  input  sha1rc_pkg::round_t      d,
  output sha1rc_pkg::round_t      q
);
  import sha1rc_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] w_new;
  round_t      q_nxt;
  round_t      q_r;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (d.b & d.c) | (~d.b & d.d);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = d.b ^ d.c ^ d.d;
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (d.b & d.c) | (d.b & d.d) | (d.c & d.d);
      k = K2;
    end else begin
      f = d.b ^ d.c ^ d.d;
      k = K3;
    end
    t = rotl(d.a, 5) + f + d.e + d.w[0] + k;
    w_new = rotl(d.w[13] ^ d.w[8] ^ d.w[2] ^ d.w[0], 1);
    q_nxt.a = t;
    q_nxt.b = d.a;
    q_nxt.c = rotl(d.b, 30);
    q_nxt.d = d.c;
    q_nxt.e = d.d;
    q_nxt.w = {w_new, d.w[15:1]};
    q_nxt.idx = d.idx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

### verif/sha1_chain_checker.sv
// ----------------------------------------------------------------------------
// sha1_chain_checker
// Watches the candidate and result streams of the chain step core, computes
// the SHA-1 digest, reduced candidate and match flag of each accepted beat,
// and compares every result beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module sha1_chain_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [71:0]                    in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [223:0]                   out_tdata,
  input  logic [0:0]                     out_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sha1rc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import sha1rc_pkg::*;

  typedef struct packed {
    logic        match;
    logic [63:0] next_text;
    logic [31:0] h4, h3, h2, h1, h0;
  } link_t;

  logic [31:0] target [NumTargets];
  link_t       link_q [$];

  function automatic logic [31:0] rol(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic link_t chain_link(logic [63:0] text, logic [6:0] idx);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, v;
    logic [31:0] dig;
    link_t r;
    for (int i = 0; i < 16; i++) w[i] = '0;
    w[0] = text[63:32];
    w[1] = text[31:0];
    w[2] = 32'h80000000;
    w[15] = 32'd64;
    for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = H0_INIT; b = H1_INIT; c = H2_INIT; d = H3_INIT; e = H4_INIT;
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rol(a, 5) + f + e + w[i] + k;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    r.h0 = H0_INIT + a; r.h1 = H1_INIT + b; r.h2 = H2_INIT + c;
    r.h3 = H3_INIT + d; r.h4 = H4_INIT + e;
    v = r.h0 + r.h1 * {25'd0, idx};
    v = v % REDUCE_MOD;
    r.next_text = {CH_A, CH_0, 48'd0};
    for (int p = 0; p < NumDigits; p++) begin
      dig = v % 36;
      r.next_text[40-8*p +: 8] = (dig < 10) ? CH_0 + dig[7:0] : CH_A + dig[7:0] - 8'd10;
      v = v / 36;
    end
    r.match = (r.h0 == target[0]) && (r.h1 == target[1]) && (r.h2 == target[2])
           && (r.h3 == target[3]) && (r.h4 == target[4]);
    return r;
  endfunction

  task automatic cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign pending_count = link_q.size();

  always @(posedge clk) begin
    link_t exp_l;
    if (!rst_n) begin
      for (int i = 0; i < NumTargets; i++) target[i] <= '0;
      link_q.delete();
    end else begin
      // result side first: a beat entering now cannot leave in the same edge
      if (out_tvalid && out_tready) begin
        if (link_q.size() == 0) begin
          $error("result beat with no prediction pending");
          fail_count++;
        end else begin
          exp_l = link_q.pop_front();
          cmp("digest_h0", exp_l.h0, out_tdata[31:0]);
          cmp("digest_h1", exp_l.h1, out_tdata[63:32]);
          cmp("digest_h2", exp_l.h2, out_tdata[95:64]);
          cmp("digest_h3", exp_l.h3, out_tdata[127:96]);
          cmp("digest_h4", exp_l.h4, out_tdata[159:128]);
          cmp("reduced_text", exp_l.next_text, out_tdata[223:160]);
          cmp("hash_match", exp_l.match, out_tuser[0]);
        end
      end
      if (in_tvalid && in_tready)
        link_q.push_back(chain_link(in_tdata[63:0], in_tdata[70:64]));
      if (cfg_valid && cfg_ready && cfg_index < NumTargets)
        target[cfg_index] <= cfg_data;
    end
  end
endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives candidates through the SHA-1 chain step core with random gaps and
// stalls, walks the target registers through several settings (including
// ones that hit real digests), and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sha1rc_pkg::*;

  localparam int PipeLatency = 90;
  localparam int CycleLimit  = 400000;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [71:0]         in_tdata;    // candidate_text[63:0], reduction_index[70:64]
  logic                out_tvalid;
  logic                out_tready;
  logic [223:0]        out_tdata;   // digest_h0..h4, reduced_text
  logic [0:0]          out_tuser;   // hash_match
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [31:0]         cfg_data;
  int                  fail_count;
  int                  pending_count;
  int                  cycle_count;
  bit                  calm;        // last part of the run: no idling
  bit                  hold_off;    // long receiver stall requested
  logic [63:0]         hit_text;    // candidate whose digest becomes the target
  logic [31:0]         hit_digest [NumTargets];

  sha1_rainbow_chain_step_core u_top (.*);

  sha1_chain_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 3);
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one candidate beat; gap bursts decided before offering it
  task automatic send_beat(logic [63:0] text, logic [6:0] idx);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, idx, text};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drop_valid();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_target(cfg_reg_t which, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_targets(logic [31:0] w0, w1, w2, w3, w4);
    write_target(REG_TGT0, w0);
    write_target(REG_TGT1, w1);
    write_target(REG_TGT2, w2);
    write_target(REG_TGT3, w3);
    write_target(REG_TGT4, w4);
  endtask

  task automatic drain();
    drop_valid();
    while (pending_count != 0) @(posedge clk);
    repeat (PipeLatency + 10) @(posedge clk);
  endtask

  // mostly alphanumeric chain candidates, sometimes raw bytes
  function automatic logic [63:0] rand_text();
    logic [63:0] t;
    int d;
    t = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      t[63:48] = {CH_A, CH_0};
      for (int i = 0; i < 6; i++) begin
        d = $urandom_range(0, 35);
        t[40-8*i +: 8] = (d < 10) ? CH_0 + 8'(d) : CH_A + 8'(d - 10);
      end
    end
    return t;
  endfunction

  function automatic logic [6:0] rand_idx();
    return ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(1, 100));
  endfunction

  initial begin
    logic [63:0]  txt;
    logic [224:0] hit_link;   // h0..h4, next_text, match from low bits up
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    hold_off  = 1'b0;
    rst_n     = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes of text and index, with targets at reset value
    send_beat(64'h0, 7'd0);
    send_beat('1, 7'd127);
    send_beat(64'h6130303030303030, 7'd1);
    send_beat(64'h617a7a7a7a7a7a7a, 7'd100);
    send_beat(64'h8000000000000001, 7'd101);
    send_beat(64'h5555555555555555, 7'd64);
    send_beat(64'hAAAAAAAAAAAAAAAA, 7'd63);
    drain();

    // targets all ones, then write an unused index: must change nothing
    set_targets('1, '1, '1, '1, '1);
    cfg_valid <= 1'b1;
    cfg_index <= CfgIdxW'(NumTargets + 1);
    cfg_data  <= 32'h0;
    @(posedge clk);
    cfg_valid <= 1'b0;
    send_beat(64'h0, 7'd5);
    send_beat('1, 7'd5);
    drain();

    // target = digest of a known candidate: hit, then a near miss per word
    hit_text = 64'h6131326162636465;
    hit_link = u_chk.chain_link(hit_text, 7'd1);
    for (int i = 0; i < NumTargets; i++) hit_digest[i] = hit_link[32*i +: 32];
    set_targets(hit_digest[0], hit_digest[1], hit_digest[2], hit_digest[3],
                hit_digest[4]);
    cfg_valid <= 1'b0;
    send_beat(hit_text, 7'd1);
    send_beat(hit_text, 7'd77);
    drain();
    for (int i = 0; i < NumTargets; i++) begin
      write_target(cfg_reg_t'(i), hit_digest[i] ^ 32'h1);
      cfg_valid <= 1'b0;
      send_beat(hit_text, 7'd9);
      drain();
      write_target(cfg_reg_t'(i), hit_digest[i]);
      cfg_valid <= 1'b0;
      @(posedge clk);
    end

    // random phases, each with its own target setting
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_targets('0, '0, '0, '0, '0);
        1: set_targets($urandom, $urandom, $urandom, $urandom, $urandom);
        3: set_targets(hit_digest[0], hit_digest[1], hit_digest[2], hit_digest[3],
                       hit_digest[4]);
        default: set_targets($urandom, '1, '0, $urandom, $urandom);
      endcase
      cfg_valid <= 1'b0;
      if (ph == 2) hold_off = 1'b1;
      if (ph == 4) calm = 1'b1;
      for (int i = 0; i < 200; i++) begin
        txt = ($urandom_range(0, 15) == 0) ? hit_text : rand_text();
        send_beat(txt, rand_idx());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

### sha1_rainbow_chain_step_core.f
rtl/sha1rc_pkg.sv
rtl/sha1rc_round.sv
rtl/sha1_rainbow_chain_step_core.sv
verif/sha1_chain_checker.sv
verif/testbench.sv
